>>> hw/rtl/mau_pkg.sv
`default_nettype none

package mau_pkg;

  // Field widths
  localparam int KP_W    = 24;
  localparam int GYRO_W  = 32;
  localparam int ACCEL_W = 18;
  localparam int STEP_W  = 24;
  localparam int QUAT_W  = 32;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 37;
  localparam int MUL_B_W = 34;
  localparam int PROD_W  = 64;

  // Square root and divider widths
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 33;
  localparam int DIVD_W = 64;
  localparam int DSR_W  = 33;
  localparam int QUO_W  = 32;

  // Default gain, 30.0 in Q8.16
  localparam logic [KP_W-1:0] KP_RESET = 24'd1966080;

endpackage

`default_nettype wire

>>> hw/rtl/mau_mul.sv
`default_nettype none

module mau_mul
  import mau_pkg::*;
(
  input  logic                       clk,
  input  logic signed [MUL_A_W-1:0]  mul_a,
  input  logic signed [MUL_B_W-1:0]  mul_b,
  output logic signed [PROD_W-1:0]   prod
);

  logic signed [MUL_A_W+MUL_B_W-1:0] full;
  logic signed [PROD_W-1:0]          prod_r;

  // Full signed product; every product used fits in 64 bits
  assign full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= signed'(full[PROD_W-1:0]);
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

>>> hw/rtl/mau_isqrt.sv
`default_nettype none

module mau_isqrt
  import mau_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  logic [RAD_W-1:0] rad_r;
  logic [RAD_W-1:0] res_r;
  logic [RAD_W-1:0] bit_r;
  logic             busy_r;
  logic             done_r;
  logic [RAD_W-1:0] trial;

  assign trial = res_r + bit_r;

  // Digit-by-digit root, one bit pair per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= rad;
        res_r  <= '0;
        bit_r  <= RAD_W'(1) << (RAD_W - 2);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (rad_r >= trial) begin
          rad_r <= rad_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign root = res_r[ROOT_W-1:0];
  assign done = done_r;

endmodule

`default_nettype wire

>>> hw/rtl/mau_div.sv
`default_nettype none

module mau_div
  import mau_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DSR_W-1:0]  divisor,
  output logic [QUO_W-1:0]  quotient,
  output logic              done
);

  localparam int CNT_W = $clog2(QUO_W);

  logic [DSR_W-1:0] rem_r;
  logic [QUO_W-1:0] quo_r;
  logic [DSR_W-1:0] dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  // Restoring division; the upper dividend half is always below the divisor
  assign trial = {rem_r, quo_r[QUO_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= DSR_W'(dividend[DIVD_W-1:QUO_W]);
        quo_r  <= dividend[QUO_W-1:0];
        dsr_r  <= divisor;
        cnt_r  <= CNT_W'(QUO_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], ge};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

>>> hw/rtl/mahony_attitude_update_top.sv
// Attitude filter update (gyro plus accelerometer), one quaternion per sample.
// Input channel in_*: valid/ready word of gyro rates (Q7.24), accelerometer
// counts and the step time (Q0.24 s). Output channel out_*: valid/ready word
// with the new quaternion (QUAT_FRAC_BITS fraction bits). cfg_*: write-only
// valid/ready port for the Q8.16 feedback gain, always ready; write it only
// while the block is idle.
// One word is processed at a time. A sequencer drives a shared registered
// multiplier (37 products, one issued per cycle), a bit-serial square root
// and a bit-serial divider. After integration, one-bit normalize shifts bring
// the largest quaternion component into range; with a zero accelerometer
// vector the first root, three divides and 15 products are skipped. in_ready
// is high only when idle, so a new word is taken only after the result of the
// last one has been accepted.
// Reset loads the identity quaternion and the default gain of 30.0.
// When the receiver stalls the result is held on out_* and no new word is
// taken until it is accepted.
`default_nettype none

module mahony_attitude_update_top
  import mau_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = 30
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [KP_W-1:0]          cfg_kp_gain,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [GYRO_W-1:0] in_gyro_x,
  input  logic signed [GYRO_W-1:0] in_gyro_y,
  input  logic signed [GYRO_W-1:0] in_gyro_z,
  input  logic signed [ACCEL_W-1:0] in_accel_x,
  input  logic signed [ACCEL_W-1:0] in_accel_y,
  input  logic signed [ACCEL_W-1:0] in_accel_z,
  input  logic [STEP_W-1:0]        in_step_seconds,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [QUAT_W-1:0] out_quat_w,
  output logic signed [QUAT_W-1:0] out_quat_x,
  output logic signed [QUAT_W-1:0] out_quat_y,
  output logic signed [QUAT_W-1:0] out_quat_z
);

  localparam int G_W   = 37;
  localparam int E_W   = 34;
  localparam int N_W   = 35;
  localparam int OP_W  = 6;
  localparam int ACC_RAD_SH = 28;
  localparam int ACC_DIV_SH = 44;

  // Multiply op codes, grouped by phase
  localparam logic [OP_W-1:0] OP_AXX = 6'd0,  OP_AYY = 6'd1,  OP_AZZ = 6'd2;
  localparam logic [OP_W-1:0] OP_Q13 = 6'd3,  OP_Q02 = 6'd4,  OP_Q01 = 6'd5;
  localparam logic [OP_W-1:0] OP_Q23 = 6'd6,  OP_Q00 = 6'd7,  OP_Q33 = 6'd8;
  localparam logic [OP_W-1:0] OP_U1V2 = 6'd9, OP_U2V1 = 6'd10, OP_U2V0 = 6'd11;
  localparam logic [OP_W-1:0] OP_U0V2 = 6'd12, OP_U0V1 = 6'd13, OP_U1V0 = 6'd14;
  localparam logic [OP_W-1:0] OP_KE0 = 6'd15, OP_KE1 = 6'd16, OP_KE2 = 6'd17;
  localparam logic [OP_W-1:0] OP_GD0 = 6'd18, OP_GD1 = 6'd19, OP_GD2 = 6'd20;
  localparam logic [OP_W-1:0] OP_N0 = 6'd21, OP_N1 = 6'd22, OP_N2 = 6'd23;
  localparam logic [OP_W-1:0] OP_N3 = 6'd24, OP_N4 = 6'd25, OP_N5 = 6'd26;
  localparam logic [OP_W-1:0] OP_N6 = 6'd27, OP_N7 = 6'd28, OP_N8 = 6'd29;
  localparam logic [OP_W-1:0] OP_N9 = 6'd30, OP_N10 = 6'd31, OP_N11 = 6'd32;
  localparam logic [OP_W-1:0] OP_NN0 = 6'd33, OP_NN1 = 6'd34;
  localparam logic [OP_W-1:0] OP_NN2 = 6'd35, OP_NN3 = 6'd36;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL, ST_ACHK, ST_ASQRT, ST_UGO, ST_UWAIT, ST_VSAT, ST_EFIN,
    ST_GLAUNCH, ST_NLAUNCH, ST_MAX, ST_SHIFT, ST_NSQGO, ST_NSQRT, ST_QGO,
    ST_QWAIT, ST_OUT
  } state_t;

  state_t                   state_r;
  state_t                   mul_ret_r;
  logic [OP_W-1:0]          op_r;
  logic [OP_W-1:0]          mul_end_r;
  logic                     iss_on_r;
  logic                     pnd_vld_r;
  logic [OP_W-1:0]          pnd_op_r;
  logic [KP_W-1:0]          kp_r;
  logic signed [QUAT_W-1:0] q_r [4];
  logic signed [G_W-1:0]    g_r [3];
  logic signed [ACCEL_W-1:0] a_r [3];
  logic [STEP_W-1:0]        dt_r;
  logic [35:0]              s_r;
  logic [ROOT_W-1:0]        r_r;
  logic signed [QUAT_W-1:0] u_r [3];
  logic signed [PROD_W-1:0] v_r [3];
  logic signed [PROD_W-1:0] e_acc_r [3];
  logic signed [E_W-1:0]    e_r [3];
  logic signed [QUAT_W-1:0] h_r [3];
  logic signed [N_W-1:0]    n_r [4];
  logic [N_W-1:0]           m_r;
  logic [RAD_W-1:0]         sum_r;
  logic [1:0]               idx_r;
  logic                     div_neg_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_f;
  logic signed [PROD_W-1:0]  prod_30;
  logic signed [PROD_W-1:0]  prod_22;
  logic signed [PROD_W-1:0]  prod_19;
  logic signed [QUAT_W-1:0]  h_sat;
  logic                      sq_start;
  logic [RAD_W-1:0]          sq_rad;
  logic [ROOT_W-1:0]         sq_root;
  logic                      sq_done;
  logic                      dv_start;
  logic [DIVD_W-1:0]         dv_dividend;
  logic [QUO_W-1:0]          dv_quo;
  logic                      dv_done;
  logic signed [QUO_W:0]     quo_s;
  logic signed [QUAT_W-1:0]  u_sat;
  logic signed [QUAT_W-1:0]  q_sat;
  logic [ACCEL_W-1:0]        a_mag;
  logic [N_W-1:0]            n_mag [4];
  logic [N_W-1:0]            m_lo;
  logic [N_W-1:0]            m_hi;
  logic [N_W-1:0]            m_max;

  // Clamp v to +-2^(F+1)
  function automatic logic signed [PROD_W-1:0] sat_v(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] lim;
    lim = 64'sd1 <<< (QUAT_FRAC_BITS + 1);
    if (x > lim) return lim;
    else if (x < -lim) return -lim;
    else return x;
  endfunction

  // Shared units
  mau_mul u_mul (.clk(clk), .mul_a(mul_a), .mul_b(mul_b), .prod(prod));

  mau_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .rad(sq_rad),
    .root(sq_root), .done(sq_done)
  );

  mau_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_dividend),
    .divisor(r_r), .quotient(dv_quo), .done(dv_done)
  );

  // Operand select for the op being issued
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op_r)
      OP_AXX:  begin mul_a = MUL_A_W'(a_r[0]); mul_b = MUL_B_W'(a_r[0]); end
      OP_AYY:  begin mul_a = MUL_A_W'(a_r[1]); mul_b = MUL_B_W'(a_r[1]); end
      OP_AZZ:  begin mul_a = MUL_A_W'(a_r[2]); mul_b = MUL_B_W'(a_r[2]); end
      OP_Q13:  begin mul_a = MUL_A_W'(q_r[1]); mul_b = MUL_B_W'(q_r[3]); end
      OP_Q02:  begin mul_a = MUL_A_W'(q_r[0]); mul_b = MUL_B_W'(q_r[2]); end
      OP_Q01:  begin mul_a = MUL_A_W'(q_r[0]); mul_b = MUL_B_W'(q_r[1]); end
      OP_Q23:  begin mul_a = MUL_A_W'(q_r[2]); mul_b = MUL_B_W'(q_r[3]); end
      OP_Q00:  begin mul_a = MUL_A_W'(q_r[0]); mul_b = MUL_B_W'(q_r[0]); end
      OP_Q33:  begin mul_a = MUL_A_W'(q_r[3]); mul_b = MUL_B_W'(q_r[3]); end
      OP_U1V2: begin mul_a = MUL_A_W'(u_r[1]); mul_b = MUL_B_W'(v_r[2]); end
      OP_U2V1: begin mul_a = MUL_A_W'(u_r[2]); mul_b = MUL_B_W'(v_r[1]); end
      OP_U2V0: begin mul_a = MUL_A_W'(u_r[2]); mul_b = MUL_B_W'(v_r[0]); end
      OP_U0V2: begin mul_a = MUL_A_W'(u_r[0]); mul_b = MUL_B_W'(v_r[2]); end
      OP_U0V1: begin mul_a = MUL_A_W'(u_r[0]); mul_b = MUL_B_W'(v_r[1]); end
      OP_U1V0: begin mul_a = MUL_A_W'(u_r[1]); mul_b = MUL_B_W'(v_r[0]); end
      OP_KE0:  begin mul_a = signed'(MUL_A_W'(kp_r)); mul_b = MUL_B_W'(e_r[0]); end
      OP_KE1:  begin mul_a = signed'(MUL_A_W'(kp_r)); mul_b = MUL_B_W'(e_r[1]); end
      OP_KE2:  begin mul_a = signed'(MUL_A_W'(kp_r)); mul_b = MUL_B_W'(e_r[2]); end
      OP_GD0:  begin mul_a = MUL_A_W'(g_r[0]); mul_b = signed'(MUL_B_W'(dt_r)); end
      OP_GD1:  begin mul_a = MUL_A_W'(g_r[1]); mul_b = signed'(MUL_B_W'(dt_r)); end
      OP_GD2:  begin mul_a = MUL_A_W'(g_r[2]); mul_b = signed'(MUL_B_W'(dt_r)); end
      OP_N0:   begin mul_a = MUL_A_W'(q_r[1]); mul_b = MUL_B_W'(h_r[0]); end
      OP_N1:   begin mul_a = MUL_A_W'(q_r[2]); mul_b = MUL_B_W'(h_r[1]); end
      OP_N2:   begin mul_a = MUL_A_W'(q_r[3]); mul_b = MUL_B_W'(h_r[2]); end
      OP_N3:   begin mul_a = MUL_A_W'(q_r[0]); mul_b = MUL_B_W'(h_r[0]); end
      OP_N4:   begin mul_a = MUL_A_W'(q_r[2]); mul_b = MUL_B_W'(h_r[2]); end
      OP_N5:   begin mul_a = MUL_A_W'(q_r[3]); mul_b = MUL_B_W'(h_r[1]); end
      OP_N6:   begin mul_a = MUL_A_W'(q_r[0]); mul_b = MUL_B_W'(h_r[1]); end
      OP_N7:   begin mul_a = MUL_A_W'(q_r[1]); mul_b = MUL_B_W'(h_r[2]); end
      OP_N8:   begin mul_a = MUL_A_W'(q_r[3]); mul_b = MUL_B_W'(h_r[0]); end
      OP_N9:   begin mul_a = MUL_A_W'(q_r[0]); mul_b = MUL_B_W'(h_r[2]); end
      OP_N10:  begin mul_a = MUL_A_W'(q_r[1]); mul_b = MUL_B_W'(h_r[1]); end
      OP_N11:  begin mul_a = MUL_A_W'(q_r[2]); mul_b = MUL_B_W'(h_r[0]); end
      OP_NN0:  begin mul_a = MUL_A_W'(n_r[0]); mul_b = MUL_B_W'(n_r[0]); end
      OP_NN1:  begin mul_a = MUL_A_W'(n_r[1]); mul_b = MUL_B_W'(n_r[1]); end
      OP_NN2:  begin mul_a = MUL_A_W'(n_r[2]); mul_b = MUL_B_W'(n_r[2]); end
      OP_NN3:  begin mul_a = MUL_A_W'(n_r[3]); mul_b = MUL_B_W'(n_r[3]); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Shifted products (arithmetic shifts floor toward minus infinity)
  assign prod_f  = prod >>> QUAT_FRAC_BITS;
  assign prod_30 = prod >>> 30;
  assign prod_22 = prod >>> 22;
  assign prod_19 = prod >>> 19;

  always_comb begin
    if (prod_19 > 64'sd2147483647) h_sat = 32'sh7FFFFFFF;
    else if (prod_19 < -64'sd2147483648) h_sat = 32'sh80000000;
    else h_sat = QUAT_W'(prod_19);
  end

  // Root and divide operands
  assign sq_start = ((state_r == ST_ACHK) && (s_r != '0)) || (state_r == ST_NSQGO);
  assign sq_rad   = (state_r == ST_NSQGO) ? sum_r : (RAD_W'(s_r) << ACC_RAD_SH);
  assign dv_start = (state_r == ST_UGO) || (state_r == ST_QGO);

  assign a_mag = a_r[idx_r][ACCEL_W-1] ? ACCEL_W'(-a_r[idx_r]) : ACCEL_W'(a_r[idx_r]);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      n_mag[i] = n_r[i][N_W-1] ? N_W'(-n_r[i]) : N_W'(n_r[i]);
    end
    m_lo  = (n_mag[0] > n_mag[1]) ? n_mag[0] : n_mag[1];
    m_hi  = (n_mag[2] > n_mag[3]) ? n_mag[2] : n_mag[3];
    m_max = (m_lo > m_hi) ? m_lo : m_hi;
  end

  assign dv_dividend = (state_r == ST_QGO) ?
                       (DIVD_W'(n_mag[idx_r]) << QUAT_FRAC_BITS) :
                       (DIVD_W'(a_mag) << ACC_DIV_SH);

  // Signed quotient and its clamps
  assign quo_s = div_neg_r ? -signed'({1'b0, dv_quo}) : signed'({1'b0, dv_quo});

  always_comb begin
    if (quo_s > 33'sd1073741824) u_sat = 32'sd1073741824;
    else if (quo_s < -33'sd1073741824) u_sat = -32'sd1073741824;
    else u_sat = QUAT_W'(quo_s);
    if (quo_s > 33'sd2147483647) q_sat = 32'sh7FFFFFFF;
    else if (quo_s < -33'sd2147483648) q_sat = 32'sh80000000;
    else q_sat = QUAT_W'(quo_s);
  end

  // Sequencer, datapath registers and result hold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mul_ret_r <= ST_IDLE;
      iss_on_r  <= 1'b0;
      pnd_vld_r <= 1'b0;
      kp_r      <= KP_RESET;
      q_r[0]    <= 32'sd1 <<< QUAT_FRAC_BITS;
      q_r[1]    <= '0;
      q_r[2]    <= '0;
      q_r[3]    <= '0;
    end else begin
      if (cfg_valid) kp_r <= cfg_kp_gain;

      pnd_vld_r <= (state_r == ST_MUL) && iss_on_r;
      pnd_op_r  <= op_r;

      // Retire the product issued last cycle
      if (pnd_vld_r) begin
        unique case (pnd_op_r)
          OP_AXX, OP_AYY, OP_AZZ: s_r <= s_r + prod[35:0];
          OP_Q13:  v_r[0] <= v_r[0] + prod_f;
          OP_Q02:  v_r[0] <= v_r[0] - prod_f;
          OP_Q01, OP_Q23: v_r[1] <= v_r[1] + prod_f;
          OP_Q00, OP_Q33: v_r[2] <= v_r[2] + prod_f;
          OP_U1V2: e_acc_r[0] <= e_acc_r[0] + prod;
          OP_U2V1: e_acc_r[0] <= e_acc_r[0] - prod;
          OP_U2V0: e_acc_r[1] <= e_acc_r[1] + prod;
          OP_U0V2: e_acc_r[1] <= e_acc_r[1] - prod;
          OP_U0V1: e_acc_r[2] <= e_acc_r[2] + prod;
          OP_U1V0: e_acc_r[2] <= e_acc_r[2] - prod;
          OP_KE0:  g_r[0] <= g_r[0] + G_W'(prod_22);
          OP_KE1:  g_r[1] <= g_r[1] + G_W'(prod_22);
          OP_KE2:  g_r[2] <= g_r[2] + G_W'(prod_22);
          OP_GD0:  h_r[0] <= h_sat;
          OP_GD1:  h_r[1] <= h_sat;
          OP_GD2:  h_r[2] <= h_sat;
          OP_N0, OP_N1, OP_N2: n_r[0] <= n_r[0] - N_W'(prod_30);
          OP_N3, OP_N4: n_r[1] <= n_r[1] + N_W'(prod_30);
          OP_N5:   n_r[1] <= n_r[1] - N_W'(prod_30);
          OP_N6, OP_N8: n_r[2] <= n_r[2] + N_W'(prod_30);
          OP_N7:   n_r[2] <= n_r[2] - N_W'(prod_30);
          OP_N9, OP_N10: n_r[3] <= n_r[3] + N_W'(prod_30);
          OP_N11:  n_r[3] <= n_r[3] - N_W'(prod_30);
          OP_NN0, OP_NN1, OP_NN2, OP_NN3: sum_r <= sum_r + unsigned'(prod);
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            g_r[0]     <= G_W'(in_gyro_x);
            g_r[1]     <= G_W'(in_gyro_y);
            g_r[2]     <= G_W'(in_gyro_z);
            a_r[0]     <= in_accel_x;
            a_r[1]     <= in_accel_y;
            a_r[2]     <= in_accel_z;
            dt_r       <= in_step_seconds;
            s_r        <= '0;
            v_r[0]     <= '0;
            v_r[1]     <= '0;
            v_r[2]     <= -(64'sd1 <<< (QUAT_FRAC_BITS - 1));
            e_acc_r[0] <= '0;
            e_acc_r[1] <= '0;
            e_acc_r[2] <= '0;
            op_r       <= OP_AXX;
            mul_end_r  <= OP_AZZ;
            mul_ret_r  <= ST_ACHK;
            iss_on_r   <= 1'b1;
            state_r    <= ST_MUL;
          end
        end
        // One product issued per cycle, then drain the last one
        ST_MUL: begin
          if (iss_on_r) begin
            if (op_r == mul_end_r) iss_on_r <= 1'b0;
            else op_r <= op_r + 1'b1;
          end else if (!pnd_vld_r) begin
            state_r <= mul_ret_r;
          end
        end
        ST_ACHK: begin
          state_r <= (s_r == '0) ? ST_GLAUNCH : ST_ASQRT;
        end
        ST_ASQRT: begin
          if (sq_done) begin
            r_r     <= sq_root;
            idx_r   <= '0;
            state_r <= ST_UGO;
          end
        end
        ST_UGO: begin
          div_neg_r <= a_r[idx_r][ACCEL_W-1];
          state_r   <= ST_UWAIT;
        end
        ST_UWAIT: begin
          if (dv_done) begin
            u_r[idx_r] <= u_sat;
            if (idx_r == 2'd2) begin
              op_r      <= OP_Q13;
              mul_end_r <= OP_Q33;
              mul_ret_r <= ST_VSAT;
              iss_on_r  <= 1'b1;
              state_r   <= ST_MUL;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= ST_UGO;
            end
          end
        end
        ST_VSAT: begin
          v_r[0]    <= sat_v(v_r[0]);
          v_r[1]    <= sat_v(v_r[1]);
          v_r[2]    <= sat_v(v_r[2]);
          op_r      <= OP_U1V2;
          mul_end_r <= OP_U1V0;
          mul_ret_r <= ST_EFIN;
          iss_on_r  <= 1'b1;
          state_r   <= ST_MUL;
        end
        ST_EFIN: begin
          e_r[0]    <= E_W'(e_acc_r[0] >>> QUAT_FRAC_BITS);
          e_r[1]    <= E_W'(e_acc_r[1] >>> QUAT_FRAC_BITS);
          e_r[2]    <= E_W'(e_acc_r[2] >>> QUAT_FRAC_BITS);
          op_r      <= OP_KE0;
          mul_end_r <= OP_KE2;
          mul_ret_r <= ST_GLAUNCH;
          iss_on_r  <= 1'b1;
          state_r   <= ST_MUL;
        end
        ST_GLAUNCH: begin
          op_r      <= OP_GD0;
          mul_end_r <= OP_GD2;
          mul_ret_r <= ST_NLAUNCH;
          iss_on_r  <= 1'b1;
          state_r   <= ST_MUL;
        end
        ST_NLAUNCH: begin
          n_r[0]    <= N_W'(q_r[0]);
          n_r[1]    <= N_W'(q_r[1]);
          n_r[2]    <= N_W'(q_r[2]);
          n_r[3]    <= N_W'(q_r[3]);
          op_r      <= OP_N0;
          mul_end_r <= OP_N11;
          mul_ret_r <= ST_MAX;
          iss_on_r  <= 1'b1;
          state_r   <= ST_MUL;
        end
        // Zero quaternion keeps the stored one
        ST_MAX: begin
          if (m_max == '0) begin
            state_r <= ST_OUT;
          end else begin
            m_r     <= m_max;
            state_r <= ST_SHIFT;
          end
        end
        // Bring the largest magnitude into [2^29, 2^30), one bit a cycle
        ST_SHIFT: begin
          if (m_r >= (N_W'(1) << 30)) begin
            m_r <= m_r >> 1;
            for (int i = 0; i < 4; i++) n_r[i] <= n_r[i] >>> 1;
          end else if (m_r < (N_W'(1) << 29)) begin
            m_r <= m_r << 1;
            for (int i = 0; i < 4; i++) n_r[i] <= n_r[i] <<< 1;
          end else begin
            sum_r     <= '0;
            op_r      <= OP_NN0;
            mul_end_r <= OP_NN3;
            mul_ret_r <= ST_NSQGO;
            iss_on_r  <= 1'b1;
            state_r   <= ST_MUL;
          end
        end
        ST_NSQGO: begin
          state_r <= ST_NSQRT;
        end
        ST_NSQRT: begin
          if (sq_done) begin
            r_r     <= sq_root;
            idx_r   <= '0;
            state_r <= ST_QGO;
          end
        end
        ST_QGO: begin
          div_neg_r <= n_r[idx_r][N_W-1];
          state_r   <= ST_QWAIT;
        end
        ST_QWAIT: begin
          if (dv_done) begin
            q_r[idx_r] <= q_sat;
            if (idx_r == 2'd3) begin
              state_r <= ST_OUT;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= ST_QGO;
            end
          end
        end
        ST_OUT: begin
          if (out_ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = (state_r == ST_OUT);
  assign out_quat_w = q_r[0];
  assign out_quat_x = q_r[1];
  assign out_quat_y = q_r[2];
  assign out_quat_z = q_r[3];

endmodule

`default_nettype wire

>>> hw/rtl/mau_chk.sv
`default_nettype none

module mau_chk
  import mau_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [QUAT_W-1:0] out_quat_w,
  input logic signed [QUAT_W-1:0] out_quat_x,
  input logic signed [QUAT_W-1:0] out_quat_y,
  input logic signed [QUAT_W-1:0] out_quat_z
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_quat_w) &&
    $stable(out_quat_x) && $stable(out_quat_y) && $stable(out_quat_z))
    else $error("result word changed while stalled");

  // One word in flight: never ready for input while a result waits
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // An accepted word occupies the block
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("block free right after input accept");

  // Result accept returns to idle
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("not idle after result accept");

endmodule

bind mahony_attitude_update_top mau_chk u_mau_chk (.*);

`default_nettype wire
